### rtl/core/quaternion_to_remapped_rotation_macros.svh
// ----------------------------------------------------------------------------
// quaternion_to_remapped_rotation assertion macros
// shared concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_REMAPPED_ROTATION_MACROS_SVH
`define QUATERNION_TO_REMAPPED_ROTATION_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define QRR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("qrr assertion failed");
// checked in every cycle, reset included
`define QRR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("qrr assertion failed");
`else
`define QRR_ASSERT(lbl, clk, rstn, prop)
`define QRR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/core/qrr_pkg.sv
// ----------------------------------------------------------------------------
// qrr_pkg
// types and constants of the quaternion to remapped rotation block
// ----------------------------------------------------------------------------
`default_nettype none
package qrr_pkg;
    localparam int NLANE = 9;   // matrix entries
    localparam int QW    = 15;  // quotient bits, covers 0..16384
    localparam int NW    = 33;  // quaternion norm, up to 2^32
    localparam int VW    = 34;  // divisor 2n
    localparam int DW    = 48;  // dividend 2|num|*2^14 + n
    localparam int SW    = 35;  // signed numerators

    typedef logic signed [15:0] t_q14;
    typedef logic signed [15:0] t_q15;

    typedef struct packed {
        logic [NLANE-1:0] neg;
        logic             zero;
    } t_side;

    localparam logic [7:0] AXIS_BAD_BITS = 8'h7C;
    localparam logic [7:0] AXIS_SEL_MASK = 8'h03;
    localparam logic [7:0] AXIS_NEG_BIT  = 8'h80;
    localparam t_q14       ONE_Q14       = 16'sd16384;
    localparam logic [7:0] FIRST_RST     = 8'd2;
    localparam logic [7:0] SECOND_RST    = 8'd129;
    localparam logic       REG_FIRST     = 1'b0;
    localparam logic       REG_SECOND    = 1'b1;

    function automatic logic codes_valid(input logic [7:0] a, input logic [7:0] b);
        logic ok;
        ok = 1'b1;
        if (((a & AXIS_BAD_BITS) != 8'd0) || ((b & AXIS_BAD_BITS) != 8'd0)) ok = 1'b0;
        if (((a & AXIS_SEL_MASK) == 8'd0) || ((b & AXIS_SEL_MASK) == 8'd0)) ok = 1'b0;
        if ((a & AXIS_SEL_MASK) == (b & AXIS_SEL_MASK)) ok = 1'b0;
        return ok;
    endfunction
endpackage
`default_nettype wire

### rtl/core/qrr_ifs.sv
// ----------------------------------------------------------------------------
// qrr channel interfaces
// quaternion input channel and matrix result channel, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none
interface qrr_quat_if;
    import qrr_pkg::*;
    logic valid;
    logic ready;
    t_q15 quat_x;
    t_q15 quat_y;
    t_q15 quat_z;
    t_q15 quat_w;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qrr_mat_if;
    import qrr_pkg::*;
    logic valid;
    logic ready;
    t_q14 m11;
    t_q14 m12;
    t_q14 m13;
    t_q14 m21;
    t_q14 m22;
    t_q14 m23;
    t_q14 m31;
    t_q14 m32;
    t_q14 m33;
    logic remap_invalid;
    logic zero_norm;
    modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    remap_invalid, zero_norm, input ready);
    modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    remap_invalid, zero_norm, output ready);
endinterface
`default_nettype wire

### rtl/core/qrr_div_pipe.sv
// ----------------------------------------------------------------------------
// qrr_div_pipe
// nine-lane restoring divider, one quotient bit per stage, shared divisor
// ----------------------------------------------------------------------------
`default_nettype none
module qrr_div_pipe (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire qrr_pkg::t_side         i_side,
    input  wire logic [qrr_pkg::VW-1:0] i_den,
    input  wire logic [qrr_pkg::DW-1:0] i_num [qrr_pkg::NLANE],
    output logic                        o_valid,
    output qrr_pkg::t_side              o_side,
    output logic [qrr_pkg::QW-1:0]      o_quo [qrr_pkg::NLANE]
);
    import qrr_pkg::*;

    logic [DW-1:0] r_rem [QW][NLANE];
    logic [DW-1:0] n_rem [QW][NLANE];
    logic [QW-1:0] r_quo [QW][NLANE];
    logic [QW-1:0] n_quo [QW][NLANE];
    logic [VW-1:0] r_den [QW];
    t_side         r_side [QW];
    logic [QW-1:0] r_vld;

    logic [DW-1:0] src_rem [QW][NLANE];
    logic [QW-1:0] src_quo [QW][NLANE];
    logic [VW-1:0] src_den [QW];

    always_comb begin
        logic [DW-1:0] trial;
        for (int s = 0; s < QW; s++) begin
            src_den[s] = (s == 0) ? i_den : r_den[(s == 0) ? 0 : s - 1];
            for (int l = 0; l < NLANE; l++) begin
                src_rem[s][l] = (s == 0) ? i_num[l] : r_rem[(s == 0) ? 0 : s - 1][l];
                src_quo[s][l] = (s == 0) ? '0 : r_quo[(s == 0) ? 0 : s - 1][l];
            end
        end
        for (int s = 0; s < QW; s++) begin
            for (int l = 0; l < NLANE; l++) begin
                trial = DW'(src_den[s]) << (QW - 1 - s);
                n_rem[s][l] = src_rem[s][l];
                n_quo[s][l] = src_quo[s][l];
                if (src_rem[s][l] >= trial) begin
                    n_rem[s][l] = src_rem[s][l] - trial;
                    n_quo[s][l][QW-1-s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_den[s]  <= src_den[s];
                r_side[s] <= (s == 0) ? i_side : r_side[(s == 0) ? 0 : s - 1];
                for (int l = 0; l < NLANE; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_quo[s][l] <= n_quo[s][l];
                end
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_side  = r_side[QW-1];
    always_comb begin
        for (int l = 0; l < NLANE; l++) o_quo[l] = r_quo[QW-1][l];
    end
endmodule
`default_nettype wire

### rtl/core/quaternion_to_remapped_rotation.sv
// ----------------------------------------------------------------------------
// quaternion_to_remapped_rotation
// quaternion to rotation matrix, axis remap and fixed row swap, Q1.15 -> Q1.14
// ----------------------------------------------------------------------------
//  channel   dir  handshake          beat contents
//  i_quat    in   valid/ready        quat_x, quat_y, quat_z, quat_w (Q1.15)
//  o_mat     out  valid/ready        m11..m33 (Q1.14), remap_invalid, zero_norm
//  apb       in   psel/penable       first_axis_code @0, second_axis_code @4
//
//  one beat in per cycle while o_mat is not stalled, through the pipeline:
//  product, sum, dividend prep, 15 divider stages (one quotient bit each)
//  and the remap/output register.
//  the whole pipeline advances when the output register is empty or taken,
//  so a stall at o_mat freezes every stage and no beat is lost or repeated.
//  synchronous active-low reset clears the valid bits and reloads the reset axis codes.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_remapped_rotation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    qrr_quat_if.sink         i_quat,
    qrr_mat_if.source        o_mat,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import qrr_pkg::*;
    `include "quaternion_to_remapped_rotation_macros.svh"

    // ---------------- configuration registers ----------------
    logic [7:0] r_first;
    logic [7:0] r_second;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= FIRST_RST;
            r_second <= SECOND_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FIRST:  r_first  <= pwdata[7:0];
                REG_SECOND: r_second <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FIRST:  prdata = {24'd0, r_first};
            REG_SECOND: prdata = {24'd0, r_second};
            default:    prdata = '0;
        endcase
    end

    // global advance: output register free or being drained
    logic r_out_vld;
    logic en;
    assign en = !r_out_vld || o_mat.ready;
    assign i_quat.ready = en;

    // ---------------- stage 1: products ----------------
    // order: xx yy zz ww xy zw xz yw yz xw
    logic              r_s1_vld;
    logic signed [31:0] r_p [10];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_vld <= 1'b0;
        else if (en)  r_s1_vld <= i_quat.valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= i_quat.quat_x * i_quat.quat_x;
            r_p[1] <= i_quat.quat_y * i_quat.quat_y;
            r_p[2] <= i_quat.quat_z * i_quat.quat_z;
            r_p[3] <= i_quat.quat_w * i_quat.quat_w;
            r_p[4] <= i_quat.quat_x * i_quat.quat_y;
            r_p[5] <= i_quat.quat_z * i_quat.quat_w;
            r_p[6] <= i_quat.quat_x * i_quat.quat_z;
            r_p[7] <= i_quat.quat_y * i_quat.quat_w;
            r_p[8] <= i_quat.quat_y * i_quat.quat_z;
            r_p[9] <= i_quat.quat_x * i_quat.quat_w;
        end
    end

    // ---------------- stage 2: norm and numerators ----------------
    logic signed [SW-1:0] e [10];
    logic signed [SW-1:0] n_norm;
    logic signed [SW-1:0] n_num [NLANE];
    logic                 r_s2_vld;
    logic signed [SW-1:0] r_norm;
    logic signed [SW-1:0] r_num [NLANE];

    always_comb begin
        for (int k = 0; k < 10; k++) e[k] = SW'(r_p[k]);
        n_norm   = e[0] + e[1] + e[2] + e[3];
        n_num[0] = n_norm - ((e[1] + e[2]) <<< 1);
        n_num[1] = (e[4] - e[5]) <<< 1;
        n_num[2] = (e[6] + e[7]) <<< 1;
        n_num[3] = (e[4] + e[5]) <<< 1;
        n_num[4] = n_norm - ((e[0] + e[2]) <<< 1);
        n_num[5] = (e[8] - e[9]) <<< 1;
        n_num[6] = (e[6] - e[7]) <<< 1;
        n_num[7] = (e[8] + e[9]) <<< 1;
        n_num[8] = n_norm - ((e[0] + e[1]) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_vld <= 1'b0;
        else if (en)  r_s2_vld <= r_s1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_norm <= n_norm;
            for (int l = 0; l < NLANE; l++) r_num[l] <= n_num[l];
        end
    end

    // ---------------- stage 3: dividend = 2|num|*2^14 + n, divisor = 2n ----------------
    logic [DW-1:0] n_dvd [NLANE];
    logic [NW-1:0] nrm_u;
    t_side         n_side;
    logic          r_s3_vld;
    logic [DW-1:0] r_dvd [NLANE];
    logic [VW-1:0] r_den;
    t_side         r_side;

    always_comb begin
        logic [SW-1:0] mag;
        nrm_u = r_norm[NW-1:0];
        for (int l = 0; l < NLANE; l++) begin
            mag = r_num[l][SW-1] ? SW'(-r_num[l]) : SW'(r_num[l]);
            n_dvd[l] = (DW'(mag[NW-1:0]) << QW) + DW'(nrm_u);
            n_side.neg[l] = r_num[l][SW-1];
        end
        n_side.zero = (nrm_u == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_vld <= 1'b0;
        else if (en)  r_s3_vld <= r_s2_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den  <= {nrm_u, 1'b0};
            r_side <= n_side;
            for (int l = 0; l < NLANE; l++) r_dvd[l] <= n_dvd[l];
        end
    end

    // ---------------- divider chain ----------------
    logic          dv_vld;
    t_side         dv_side;
    logic [QW-1:0] dv_quo [NLANE];

    qrr_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_vld),
        .i_side  (r_side),
        .i_den   (r_den),
        .i_num   (r_dvd),
        .o_valid (dv_vld),
        .o_side  (dv_side),
        .o_quo   (dv_quo)
    );

    // ---------------- remap and fixed row move ----------------
    t_q14       rot [3][3];
    t_q14       mrm [3][3];
    t_q14       fin [3][3];
    logic       rm_ok;
    logic [7:0] az;
    logic [1:0] cx, cy, cz;
    logic       sx, sy, sz;
    logic       flip;

    always_comb begin
        t_q14 q;
        t_q14 a0, a1, a2;
        // rounded entries of the normalized rotation, identity for zero norm
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                q = (dv_quo[3*j+i] > QW'(ONE_Q14)) ? ONE_Q14 : t_q14'(dv_quo[3*j+i]);
                if (dv_side.zero) rot[j][i] = (i == j) ? ONE_Q14 : '0;
                else              rot[j][i] = dv_side.neg[3*j+i] ? -q : q;
            end
        end

        rm_ok = codes_valid(r_first, r_second);
        az    = r_first ^ r_second;
        cx    = r_first[1:0] - 2'd1;
        cy    = r_second[1:0] - 2'd1;
        cz    = az[1:0] - 2'd1;
        // right-handed only when x follows z and y follows x, mod 3
        flip  = (cx != ((cz == 2'd2) ? 2'd0 : cz + 2'd1)) ||
                (cy != ((cz == 2'd0) ? 2'd2 : cz - 2'd1));
        sx    = r_first[7];
        sy    = r_second[7];
        sz    = az[7] ^ flip;

        for (int j = 0; j < 3; j++) begin
            a0 = sx ? -rot[j][0] : rot[j][0];
            a1 = sy ? -rot[j][1] : rot[j][1];
            a2 = sz ? -rot[j][2] : rot[j][2];
            for (int i = 0; i < 3; i++) begin
                if (!rm_ok)             mrm[j][i] = (i == j) ? ONE_Q14 : '0;
                else if (2'(i) == cx)   mrm[j][i] = a0;
                else if (2'(i) == cy)   mrm[j][i] = a1;
                else                    mrm[j][i] = a2;
            end
        end

        // keep row 1, row 3 up to row 2, row 2 negated down to row 3
        for (int i = 0; i < 3; i++) begin
            fin[0][i] = mrm[0][i];
            fin[1][i] = mrm[2][i];
            fin[2][i] = -mrm[1][i];
        end
    end

    // ---------------- output register ----------------
    t_q14 r_fin [3][3];
    logic r_inv;
    logic r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (en)  r_out_vld <= dv_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin  <= fin;
            r_inv  <= !rm_ok;
            r_zero <= dv_side.zero;
        end
    end

    assign o_mat.valid         = r_out_vld;
    assign o_mat.m11           = r_fin[0][0];
    assign o_mat.m12           = r_fin[0][1];
    assign o_mat.m13           = r_fin[0][2];
    assign o_mat.m21           = r_fin[1][0];
    assign o_mat.m22           = r_fin[1][1];
    assign o_mat.m23           = r_fin[1][2];
    assign o_mat.m31           = r_fin[2][0];
    assign o_mat.m32           = r_fin[2][1];
    assign o_mat.m33           = r_fin[2][2];
    assign o_mat.remap_invalid = r_inv;
    assign o_mat.zero_norm     = r_zero;

    // ---------------- assertions ----------------
    `QRR_ASSERT_ALWAYS(a_out_clear_after_reset, i_clk, !i_rst_n |=> !o_mat.valid)
    `QRR_ASSERT(a_stall_blocks_input, i_clk, i_rst_n,
        (o_mat.valid && !o_mat.ready) |-> !i_quat.ready)
    `QRR_ASSERT(a_invalid_flag_tracks_codes, i_clk, i_rst_n,
        o_mat.valid |-> (o_mat.remap_invalid == !codes_valid(r_first, r_second)))
    `QRR_ASSERT(a_invalid_gives_fixed_matrix, i_clk, i_rst_n,
        (o_mat.valid && o_mat.remap_invalid) |->
        (o_mat.m11 == ONE_Q14 && o_mat.m23 == ONE_Q14 && o_mat.m32 == -ONE_Q14 &&
         o_mat.m12 == 16'sd0 && o_mat.m33 == 16'sd0))
endmodule
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// quaternion_to_remapped_rotation testbench
// drives quaternion beats through the block under several axis-code settings,
// predicts each rotation matrix in fixed point and compares every result beat
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import qrr_pkg::*;

    typedef struct {
        logic signed [15:0] m [9];
        logic               inv;
        logic               zn;
    } t_expect_mat;

    // scoreboard: predicts the matrix of each accepted quaternion
    class mat_scoreboard;
        logic [7:0]  code_a;
        logic [7:0]  code_b;
        t_expect_mat pending[$];
        int          errors;

        function new();
            code_a = FIRST_RST;
            code_b = SECOND_RST;
            errors = 0;
        endfunction

        // nearest Q1.14 of num/den, ties away from zero, clamp at one
        function automatic longint round_q14(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num * 16384 : num * 16384;
            q = (2 * mag + den) / (2 * den);
            if (q > 16384) q = 16384;
            return (num < 0) ? -q : q;
        endfunction

        function void note_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                                logic signed [15:0] qz, logic signed [15:0] qw);
            longint x, y, z, w, xx, yy, zz, ww, n;
            longint r[3][3];
            longint mm[3][3];
            t_expect_mat e;
            logic [7:0] c3;
            int ix, iy, iz;
            bit sx, sy, sz;
            x = qx; y = qy; z = qz; w = qw;
            xx = x * x; yy = y * y; zz = z * z; ww = w * w;
            n = xx + yy + zz + ww;
            e.zn = (n == 0);
            if (e.zn) begin
                for (int j = 0; j < 3; j++)
                    for (int i = 0; i < 3; i++) r[j][i] = (i == j) ? 16384 : 0;
            end else begin
                r[0][0] = round_q14(n - 2 * (yy + zz), n);
                r[0][1] = round_q14(2 * (x * y - z * w), n);
                r[0][2] = round_q14(2 * (x * z + y * w), n);
                r[1][0] = round_q14(2 * (x * y + z * w), n);
                r[1][1] = round_q14(n - 2 * (xx + zz), n);
                r[1][2] = round_q14(2 * (y * z - x * w), n);
                r[2][0] = round_q14(2 * (x * z - y * w), n);
                r[2][1] = round_q14(2 * (y * z + x * w), n);
                r[2][2] = round_q14(n - 2 * (xx + yy), n);
            end
            e.inv = 1'b0;
            if ((code_a & AXIS_BAD_BITS) != 0 || (code_b & AXIS_BAD_BITS) != 0) e.inv = 1'b1;
            if ((code_a & AXIS_SEL_MASK) == 0 || (code_b & AXIS_SEL_MASK) == 0) e.inv = 1'b1;
            if ((code_a & AXIS_SEL_MASK) == (code_b & AXIS_SEL_MASK)) e.inv = 1'b1;
            if (e.inv) begin
                for (int j = 0; j < 3; j++)
                    for (int i = 0; i < 3; i++) mm[j][i] = (i == j) ? 16384 : 0;
            end else begin
                c3 = code_a ^ code_b;
                ix = int'(code_a & AXIS_SEL_MASK) - 1;
                iy = int'(code_b & AXIS_SEL_MASK) - 1;
                iz = int'(c3 & AXIS_SEL_MASK) - 1;
                // derived axis flips sign unless the triple is right-handed
                if (ix != (iz + 1) % 3 || iy != (iz + 2) % 3) c3 = c3 ^ AXIS_NEG_BIT;
                sx = (code_a & AXIS_NEG_BIT) != 0;
                sy = (code_b & AXIS_NEG_BIT) != 0;
                sz = (c3 & AXIS_NEG_BIT) != 0;
                for (int j = 0; j < 3; j++) begin
                    mm[j][ix] = sx ? -r[j][0] : r[j][0];
                    mm[j][iy] = sy ? -r[j][1] : r[j][1];
                    mm[j][iz] = sz ? -r[j][2] : r[j][2];
                end
            end
            for (int i = 0; i < 3; i++) begin
                e.m[i]     = 16'(mm[0][i]);
                e.m[3 + i] = 16'(mm[2][i]);
                e.m[6 + i] = 16'(-mm[1][i]);
            end
            pending.push_back(e);
        endfunction

        function void check_mat(logic signed [15:0] got [9], logic inv, logic zn);
            t_expect_mat e;
            if (pending.size() == 0) begin
                $error("unexpected matrix beat");
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int k = 0; k < 9; k++)
                if (got[k] !== e.m[k]) begin
                    $error("m%0d%0d expected %0d actual %0d", k / 3 + 1, k % 3 + 1,
                           e.m[k], got[k]);
                    errors++;
                end
            if (inv !== e.inv) begin
                $error("remap_invalid expected %0d actual %0d", e.inv, inv);
                errors++;
            end
            if (zn !== e.zn) begin
                $error("zero_norm expected %0d actual %0d", e.zn, zn);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    qrr_quat_if quat_ch();
    qrr_mat_if  mat_ch();

    quaternion_to_remapped_rotation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_ch.sink),
        .o_mat   (mat_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mat_scoreboard sb;
    int send_idle_pct;  // chance per cycle that the sender holds off
    int recv_idle_pct;  // chance per cycle that the receiver stalls

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20ms;
        $display("testbench NOT OK");
        $finish;
    end

    // receiver: random stalls, every accepted beat goes to the scoreboard
    always @(posedge i_clk) begin
        logic signed [15:0] got [9];
        if (!i_rst_n) begin
            mat_ch.ready <= 1'b0;
        end else begin
            if (mat_ch.valid && mat_ch.ready) begin
                got = '{mat_ch.m11, mat_ch.m12, mat_ch.m13, mat_ch.m21, mat_ch.m22,
                        mat_ch.m23, mat_ch.m31, mat_ch.m32, mat_ch.m33};
                sb.check_mat(got, mat_ch.remap_invalid, mat_ch.zero_norm);
            end
            mat_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // apb write: setup then access, pready is always high
    task automatic write_code(logic reg_sel, logic [7:0] code);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {16'($urandom_range(16'hFFFF)), 8'($urandom), code};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_FIRST) sb.code_a = code;
        else sb.code_b = code;
    endtask

    // one quaternion beat, held until taken; valid stays high for the next beat
    task automatic send_quat(logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                             logic [15:0] qw);
        while ($urandom_range(99) < send_idle_pct) begin
            quat_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        quat_ch.valid  <= 1'b1;
        quat_ch.quat_x <= qx;
        quat_ch.quat_y <= qy;
        quat_ch.quat_z <= qz;
        quat_ch.quat_w <= qw;
        do @(posedge i_clk); while (!quat_ch.ready);
        sb.note_quat(qx, qy, qz, qw);
    endtask

    // drop valid, wait for the pipeline to drain, then idle through the latency
    task automatic drain();
        quat_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_code();
        logic [7:0] c;
        if ($urandom_range(9) < 7) begin
            c = 8'($urandom_range(3, 1));
            if ($urandom_range(1)) c = c | AXIS_NEG_BIT;
        end else begin
            c = 8'($urandom);
        end
        return c;
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++)
            send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endtask

    // settings walked through the phases, including invalid and the extremes
    logic [7:0] code_list_a [8] = '{8'h01, 8'h83, 8'h02, 8'h00, 8'hFF, 8'h81, 8'h03, 8'h82};
    logic [7:0] code_list_b [8] = '{8'h02, 8'h81, 8'h83, 8'h01, 8'h00, 8'h81, 8'h82, 8'h7F};

    initial begin
        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        quat_ch.valid = 1'b0;
        quat_ch.quat_x = '0; quat_ch.quat_y = '0; quat_ch.quat_z = '0; quat_ch.quat_w = '0;
        mat_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset codes, extremes, zero quaternion, identity, ties
        send_idle_pct = 13; recv_idle_pct = 71;
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
        send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0001, 16'h0001, 16'h0000, 16'h0000);
        send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0000);
        send_quat(16'hFFFF, 16'h0001, 16'h0002, 16'hFFFD);
        send_quat(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0);
        drain();
        // same codes for both axes, then bad bits
        write_code(REG_FIRST, 8'h01);
        write_code(REG_SECOND, 8'h81);
        send_quat(16'h1234, 16'h4321, 16'h8000, 16'h7FFF);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drain();
        write_code(REG_FIRST, 8'h7F);
        write_code(REG_SECOND, 8'h02);
        send_quat(16'h1234, 16'h4321, 16'h8000, 16'h7FFF);
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p == 3) begin send_idle_pct = 71; recv_idle_pct = 13; end
            if (p == 6) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            write_code(REG_FIRST, code_list_a[p]);
            write_code(REG_SECOND, code_list_b[p]);
            random_phase(110);
            drain();
            write_code(REG_FIRST, rand_code());
            write_code(REG_SECOND, rand_code());
            random_phase(90);
            drain();
        end

        if (sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/qrr_pkg.sv
rtl/core/qrr_ifs.sv
rtl/core/qrr_div_pipe.sv
rtl/core/quaternion_to_remapped_rotation.sv
tb/testbench.sv
